/* hw/rtl/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, constants and the divider step for the point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int TRIG_SHIFT        = 10;
   localparam int TRIG_SCALE        = 1 << TRIG_SHIFT;
   localparam int CENTRE_X          = 64;
   localparam int CENTRE_Y          = 32;
   localparam int RADIUS_MAX        = 300;
   localparam int MAG_W             = 46;
   localparam int DIV_W             = 32;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COS_PITCH,
      CSR_SIN_PITCH,
      CSR_COS_YAW,
      CSR_SIN_YAW,
      CSR_CAMERA_X,
      CSR_CAMERA_Y,
      CSR_CAMERA_Z,
      CSR_FOCAL_LENGTH
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic [7:0]         point_radius;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic [8:0]         screen_radius;
   } rsp_type;

   typedef struct packed {
      logic             vis;
      logic             x_neg;
      logic             y_neg;
      logic [MAG_W-1:0] x_mag;
      logic [MAG_W-1:0] y_mag;
      logic [MAG_W-1:0] r_mag;
      logic [DIV_W-1:0] divisor;
   } work_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [MAG_W-1:0] num;
   } div_lane_type;

   function automatic div_lane_type div_step(div_lane_type cur, logic [DIV_W-1:0] d);
      logic [DIV_W:0] t;
      logic           q;
      div_lane_type   nxt;
      t = {cur.rem, cur.num[MAG_W-1]};
      q = (t >= {1'b0, d});
      if (q) begin
         nxt.rem = DIV_W'(t - {1'b0, d});
      end else begin
         nxt.rem = t[DIV_W-1:0];
      end
      nxt.num = {cur.num[MAG_W-2:0], q};
      return nxt;
   endfunction

endpackage

/* hw/rtl/ppp_front.sv */
// ----------------------------------------------------------------------------
// ppp_front
// Config registers, camera offset, rotation and numerator build-up.
// ----------------------------------------------------------------------------
module ppp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ppp_pkg::req_type                      req_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ppp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                  work_valid,
   input  logic                                  work_ready,
   output ppp_pkg::work_type                     work_data
);

   logic signed [11:0] cp_ff, sp_ff, cy_ff, sy_ff;
   logic signed [15:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [11:0]        focal_ff;

   logic signed [23:0] k_ya_ff, k_yc_ff, k_da_ff, k_dc_ff;

   logic [4:0]         v_ff;
   logic               adv;

   logic signed [16:0] dx_ff, dy_ff, dz_ff;
   logic [7:0]         r1_ff, r2_ff, r3_ff;

   logic signed [28:0] m_xa_ff, m_xb_ff, m_yb_ff, m_db_ff;
   logic signed [40:0] m_ya_ff, m_yc_ff, m_da_ff, m_dc_ff;

   logic signed [29:0] xr_ff;
   logic signed [32:0] yr_ff, dep_ff;

   logic signed [ppp_pkg::MAG_W:0] nx_ff, ny_ff;
   logic [ppp_pkg::MAG_W-1:0]      nr_ff;
   logic signed [32:0]             dep4_ff;
   logic                           vis4_ff;

   ppp_pkg::work_type work_ff;

   logic signed [40:0] ya_q, yc_q, da_q, dc_q;
   logic signed [12:0] f_s;
   logic [19:0]        rf;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff    <= 12'sd1024;
         sp_ff    <= '0;
         cy_ff    <= 12'sd1024;
         sy_ff    <= '0;
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         focal_ff <= 12'd256;
      end else if (csr_valid) begin
         unique case (ppp_pkg::csr_index_type'(csr_index))
            ppp_pkg::CSR_COS_PITCH:    cp_ff    <= csr_data[11:0];
            ppp_pkg::CSR_SIN_PITCH:    sp_ff    <= csr_data[11:0];
            ppp_pkg::CSR_COS_YAW:      cy_ff    <= csr_data[11:0];
            ppp_pkg::CSR_SIN_YAW:      sy_ff    <= csr_data[11:0];
            ppp_pkg::CSR_CAMERA_X:     cam_x_ff <= csr_data;
            ppp_pkg::CSR_CAMERA_Y:     cam_y_ff <= csr_data;
            ppp_pkg::CSR_CAMERA_Z:     cam_z_ff <= csr_data;
            ppp_pkg::CSR_FOCAL_LENGTH: focal_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // rotation coefficient products, registered from the config registers
   always_ff @(posedge clock) begin
      k_ya_ff <= -(24'(sp_ff) * 24'(sy_ff));
      k_yc_ff <= 24'(sp_ff) * 24'(cy_ff);
      k_da_ff <= 24'(cp_ff) * 24'(sy_ff);
      k_dc_ff <= 24'(cp_ff) * 24'(cy_ff);
   end

   assign adv        = !v_ff[4] || work_ready;
   assign req_ready  = adv;
   assign work_valid = v_ff[4];
   assign work_data  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[3:0], req_valid};
      end
   end

   always_comb begin
      ya_q = m_ya_ff / ppp_pkg::TRIG_SCALE;
      yc_q = m_yc_ff / ppp_pkg::TRIG_SCALE;
      da_q = m_da_ff / ppp_pkg::TRIG_SCALE;
      dc_q = m_dc_ff / ppp_pkg::TRIG_SCALE;
      f_s  = $signed({1'b0, focal_ff});
      rf   = 20'(r3_ff) * 20'(focal_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= 17'(req_payload.point_x) - 17'(cam_x_ff);
         dy_ff   <= 17'(req_payload.point_y) - 17'(cam_y_ff);
         dz_ff   <= 17'(req_payload.point_z) - 17'(cam_z_ff);
         r1_ff   <= req_payload.point_radius;

         m_xa_ff <= 29'(cy_ff) * 29'(dx_ff);
         m_xb_ff <= 29'(sy_ff) * 29'(dz_ff);
         m_ya_ff <= 41'(k_ya_ff) * 41'(dx_ff);
         m_yb_ff <= 29'(cp_ff) * 29'(dy_ff);
         m_yc_ff <= 41'(k_yc_ff) * 41'(dz_ff);
         m_da_ff <= 41'(k_da_ff) * 41'(dx_ff);
         m_db_ff <= 29'(sp_ff) * 29'(dy_ff);
         m_dc_ff <= 41'(k_dc_ff) * 41'(dz_ff);
         r2_ff   <= r1_ff;

         xr_ff   <= 30'(m_xa_ff) - 30'(m_xb_ff);
         yr_ff   <= 33'(ya_q) + 33'(m_yb_ff) - 33'(yc_q);
         dep_ff  <= 33'(da_q) + 33'(m_db_ff) + 33'(dc_q);
         r3_ff   <= r2_ff;

         nx_ff   <= (ppp_pkg::MAG_W+1)'(xr_ff) * (ppp_pkg::MAG_W+1)'(f_s);
         ny_ff   <= (ppp_pkg::MAG_W+1)'(yr_ff) * (ppp_pkg::MAG_W+1)'(f_s);
         nr_ff   <= ppp_pkg::MAG_W'(rf) << ppp_pkg::TRIG_SHIFT;
         dep4_ff <= dep_ff;
         vis4_ff <= (dep_ff > 33'sd0);

         work_ff.vis     <= vis4_ff;
         work_ff.x_neg   <= nx_ff[ppp_pkg::MAG_W];
         work_ff.y_neg   <= ny_ff[ppp_pkg::MAG_W];
         work_ff.x_mag   <= ppp_pkg::MAG_W'(nx_ff[ppp_pkg::MAG_W] ? -nx_ff : nx_ff);
         work_ff.y_mag   <= ppp_pkg::MAG_W'(ny_ff[ppp_pkg::MAG_W] ? -ny_ff : ny_ff);
         work_ff.r_mag   <= nr_ff;
         work_ff.divisor <= vis4_ff ? dep4_ff[ppp_pkg::DIV_W-1:0] : ppp_pkg::DIV_W'(1);
      end
   end

endmodule

/* hw/rtl/ppp_queue.sv */
// ----------------------------------------------------------------------------
// ppp_queue
// Small FIFO of work words between front and back.
// ----------------------------------------------------------------------------
module ppp_queue #(
   parameter int DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ppp_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ppp_pkg::work_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ppp_pkg::work_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/ppp_back.sv */
// ----------------------------------------------------------------------------
// ppp_back
// Pipelined restoring division by depth, centre offset, saturation, clamp.
// ----------------------------------------------------------------------------
module ppp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              work_valid,
   output logic              work_ready,
   input  ppp_pkg::work_type work_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppp_pkg::rsp_type  rsp_payload
);

   localparam int NS  = ppp_pkg::MAG_W;
   localparam int EXW = ppp_pkg::MAG_W + 2;

   typedef struct packed {
      logic                          vis;
      logic                          x_neg;
      logic                          y_neg;
      logic [ppp_pkg::DIV_W-1:0]     divisor;
      ppp_pkg::div_lane_type         x;
      ppp_pkg::div_lane_type         y;
      ppp_pkg::div_lane_type         r;
   } stage_type;

   stage_type        src [NS];
   stage_type        st_in [NS];
   stage_type        st_ff [NS];
   logic [NS-1:0]    v_ff;
   logic             out_v_ff;
   ppp_pkg::rsp_type out_ff;
   ppp_pkg::rsp_type out_in;
   logic             adv;

   logic signed [EXW-1:0] sx_full, sy_full;
   logic [ppp_pkg::MAG_W-1:0] qx, qy, qr;
   stage_type             last;

   localparam logic signed [EXW-1:0] SAT_HI = EXW'(32767);
   localparam logic signed [EXW-1:0] SAT_LO = -EXW'(32768);

   assign adv         = !out_v_ff || rsp_ready;
   assign work_ready  = adv;
   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      src[0].vis      = work_data.vis;
      src[0].x_neg    = work_data.x_neg;
      src[0].y_neg    = work_data.y_neg;
      src[0].divisor  = work_data.divisor;
      src[0].x        = '{rem: '0, num: work_data.x_mag};
      src[0].y        = '{rem: '0, num: work_data.y_mag};
      src[0].r        = '{rem: '0, num: work_data.r_mag};
      for (int k = 1; k < NS; k++) begin
         src[k] = st_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         st_in[k]   = src[k];
         st_in[k].x = ppp_pkg::div_step(src[k].x, src[k].divisor);
         st_in[k].y = ppp_pkg::div_step(src[k].y, src[k].divisor);
         st_in[k].r = ppp_pkg::div_step(src[k].r, src[k].divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[NS-2:0], work_valid};
         out_v_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff  <= st_in;
         out_ff <= out_in;
      end
   end

   always_comb begin
      last    = st_ff[NS-1];
      qx      = last.x.num;
      qy      = last.y.num;
      qr      = last.r.num;
      sx_full = (last.x_neg ? -$signed(EXW'(qx)) : $signed(EXW'(qx)))
                + EXW'(ppp_pkg::CENTRE_X);
      sy_full = (last.y_neg ? -$signed(EXW'(qy)) : $signed(EXW'(qy)))
                + EXW'(ppp_pkg::CENTRE_Y);
      out_in  = '0;
      if (last.vis) begin
         out_in.visible = 1'b1;
         if (sx_full > SAT_HI) begin
            out_in.screen_x = 16'sh7fff;
         end else if (sx_full < SAT_LO) begin
            out_in.screen_x = 16'sh8000;
         end else begin
            out_in.screen_x = sx_full[15:0];
         end
         if (sy_full > SAT_HI) begin
            out_in.screen_y = 16'sh7fff;
         end else if (sy_full < SAT_LO) begin
            out_in.screen_y = 16'sh8000;
         end else begin
            out_in.screen_y = sy_full[15:0];
         end
         if (qr > ppp_pkg::MAG_W'(ppp_pkg::RADIUS_MAX)) begin
            out_in.screen_radius = 9'(ppp_pkg::RADIUS_MAX);
         end else begin
            out_in.screen_radius = qr[8:0];
         end
      end
   end

endmodule

/* hw/rtl/point_perspective_projection_top.sv */
// ----------------------------------------------------------------------------
// point_perspective_projection_top
// Sphere to screen projection: camera offset, yaw/pitch rotation, divide.
// ----------------------------------------------------------------------------
// Takes one sphere word per clock while rsp_ready back-pressure does not stall
// the pipeline, and returns one result word per sphere, in order. A request
// passes through five front stages, one queue slot, 46 stages of the
// one-bit-per-stage division by depth and the output register.
// Config writes are taken every cycle and must only be issued while idle.
module point_perspective_projection_top #(
   parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ppp_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ppp_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic              f_valid, f_ready, b_valid, b_ready;
   ppp_pkg::work_type f_data, b_data;

   ppp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .work_valid  (f_valid),
      .work_ready  (f_ready),
      .work_data   (f_data)
   );

   ppp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   ppp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .work_valid  (b_valid),
      .work_ready  (b_ready),
      .work_data   (b_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/ppp_checker.sv */
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module ppp_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ppp_pkg::rsp_type rsp_payload
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response word dropped or changed");

   a_culled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.visible |->
         rsp_payload.screen_x == 16'sd0 && rsp_payload.screen_y == 16'sd0 &&
         rsp_payload.screen_radius == 9'd0)
      else $error("culled word carries nonzero fields");

   a_radius_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.screen_radius <= 9'(ppp_pkg::RADIUS_MAX))
      else $error("screen radius above clamp");

endmodule

bind point_perspective_projection_top ppp_checker u_ppp_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks point_perspective_projection_top against a cycle-free predictor.
// Camera settings are written between phases while the block is idle. After
// directed spheres, each phase streams random spheres with random stalls on
// both channels (not phase 4), comparing each result word in order, per field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  DRAIN_CYCLES = 60;
   localparam int  NUM_PHASES   = 10;
   localparam int  PER_PHASE    = 125;
   localparam int  CYCLE_LIMIT  = 500000;
   localparam int  HOLD_CYCLES  = 300;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ppp_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ppp_pkg::rsp_type rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [ppp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ppp_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   // camera settings as the block should hold them
   logic signed [11:0] cam_cp, cam_sp, cam_cy, cam_sy;
   logic signed [15:0] cam_x, cam_y, cam_z;
   logic        [11:0] cam_focal;

   ppp_pkg::req_type spheres_pending[$];
   ppp_pkg::rsp_type screen_expected[$];
   int      errors = 0;
   int      cycles = 0;
   int      spheres_sent = 0;
   int      visible_seen = 0;
   int      culled_seen = 0;
   int      phase_no = 0;
   int      hold_cnt = 0;
   bit      req_taken = 1'b0;

   point_perspective_projection_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic ppp_pkg::rsp_type project_sphere(ppp_pkg::req_type p);
      longint s, cp, sp, cy, sy, f, dx, dy, dz, xr, yr, dep, v;
      ppp_pkg::rsp_type o;
      s  = ppp_pkg::TRIG_SCALE;
      cp = cam_cp;
      sp = cam_sp;
      cy = cam_cy;
      sy = cam_sy;
      f  = longint'({1'b0, cam_focal});
      dx = longint'(p.point_x) - longint'(cam_x);
      dy = longint'(p.point_y) - longint'(cam_y);
      dz = longint'(p.point_z) - longint'(cam_z);
      xr  = cy * dx - sy * dz;
      yr  = (-sp * sy * dx) / s + cp * dy - (sp * cy * dz) / s;
      dep = (cp * sy * dx) / s + sp * dy + (cp * cy * dz) / s;
      o = '0;
      if (dep > 0) begin
         o.visible = 1'b1;
         v = xr * f / dep + ppp_pkg::CENTRE_X;
         o.screen_x = (v > 32767) ? 16'sh7fff : (v < -32768) ? 16'sh8000 : 16'(v);
         v = yr * f / dep + ppp_pkg::CENTRE_Y;
         o.screen_y = (v > 32767) ? 16'sh7fff : (v < -32768) ? 16'sh8000 : 16'(v);
         v = longint'(p.point_radius) * f * s / dep;
         o.screen_radius = (v > ppp_pkg::RADIUS_MAX) ? 9'(ppp_pkg::RADIUS_MAX) : 9'(v);
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
   endtask

   task automatic write_csr(ppp_pkg::csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ppp_pkg::CSR_COS_PITCH:    cam_cp = val[11:0];
         ppp_pkg::CSR_SIN_PITCH:    cam_sp = val[11:0];
         ppp_pkg::CSR_COS_YAW:      cam_cy = val[11:0];
         ppp_pkg::CSR_SIN_YAW:      cam_sy = val[11:0];
         ppp_pkg::CSR_CAMERA_X:     cam_x = val;
         ppp_pkg::CSR_CAMERA_Y:     cam_y = val;
         ppp_pkg::CSR_CAMERA_Z:     cam_z = val;
         ppp_pkg::CSR_FOCAL_LENGTH: cam_focal = val[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_camera(int cp, int sp, int cy, int sy,
                               int x, int y, int z, int f);
      write_csr(ppp_pkg::CSR_COS_PITCH, 16'(cp));
      write_csr(ppp_pkg::CSR_SIN_PITCH, 16'(sp));
      write_csr(ppp_pkg::CSR_COS_YAW, 16'(cy));
      write_csr(ppp_pkg::CSR_SIN_YAW, 16'(sy));
      write_csr(ppp_pkg::CSR_CAMERA_X, 16'(x));
      write_csr(ppp_pkg::CSR_CAMERA_Y, 16'(y));
      write_csr(ppp_pkg::CSR_CAMERA_Z, 16'(z));
      write_csr(ppp_pkg::CSR_FOCAL_LENGTH, 16'(f));
   endtask

   function automatic ppp_pkg::req_type make_sphere(int x, int y, int z, int r);
      ppp_pkg::req_type p;
      p.point_x = 16'(x);
      p.point_y = 16'(y);
      p.point_z = 16'(z);
      p.point_radius = 8'(r);
      return p;
   endfunction

   function automatic ppp_pkg::req_type random_sphere();
      ppp_pkg::req_type p;
      p = ppp_pkg::req_type'($bits(ppp_pkg::req_type)'({$urandom, $urandom}));
      if ($urandom_range(3) != 0) begin
         // near the camera so projections land on screen
         p.point_x = cam_x + 16'($signed($urandom_range(400)) - 200);
         p.point_y = cam_y + 16'($signed($urandom_range(400)) - 200);
         p.point_z = cam_z + 16'($signed($urandom_range(600)) - 100);
      end
      return p;
   endfunction

   task automatic drain();
      while (spheres_pending.size() != 0 || screen_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request side: accept at posedge, drive at negedge
   always @(posedge clock) begin
      cycles++;
      req_taken <= (!reset && req_valid && req_ready);
      if (!reset && req_valid && req_ready) begin
         screen_expected.push_back(project_sphere(req_payload));
         void'(spheres_pending.pop_front());
         spheres_sent++;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      bit calm;
      calm = (phase_no == 4);
      if (!reset && (!req_valid || req_taken)) begin
         if (spheres_pending.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
            req_valid   <= 1'b1;
            req_payload <= spheres_pending[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (phase_no == 2 && hold_cnt < HOLD_CYCLES) begin
         hold_cnt  <= hold_cnt + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (phase_no == 4) || ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      ppp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_expected.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = screen_expected.pop_front();
            if (rsp_payload.visible) visible_seen++; else culled_seen++;
            if (rsp_payload.visible !== want.visible)
               report_mismatch("visible", rsp_payload.visible, want.visible);
            if (rsp_payload.screen_x !== want.screen_x)
               report_mismatch("screen_x", rsp_payload.screen_x, want.screen_x);
            if (rsp_payload.screen_y !== want.screen_y)
               report_mismatch("screen_y", rsp_payload.screen_y, want.screen_y);
            if (rsp_payload.screen_radius !== want.screen_radius)
               report_mismatch("screen_radius", rsp_payload.screen_radius,
                               want.screen_radius);
         end
      end
   end

   initial begin
      cam_cp = 12'sd1024; cam_sp = '0; cam_cy = 12'sd1024; cam_sy = '0;
      cam_x = '0; cam_y = '0; cam_z = '0; cam_focal = 12'd256;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset camera: depth is dz scaled
      spheres_pending.push_back(make_sphere(0, 0, 100, 10));
      spheres_pending.push_back(make_sphere(0, 0, 0, 255));        // depth zero
      spheres_pending.push_back(make_sphere(5, 5, -1, 1));         // behind camera
      spheres_pending.push_back(make_sphere(0, 0, -32768, 255));
      spheres_pending.push_back(make_sphere(32767, -32768, 1, 255)); // saturate
      spheres_pending.push_back(make_sphere(-32768, 32767, 1, 0));
      spheres_pending.push_back(make_sphere(32767, 32767, 32767, 255));
      spheres_pending.push_back(make_sphere(-32768, -32768, 32767, 0));
      spheres_pending.push_back(make_sphere(100, -50, 1, 200));    // radius clamp
      spheres_pending.push_back(make_sphere(-7, 7, 3, 1));
      drain();
      write_camera(-1024, -1024, -1024, -1024, -32768, -32768, -32768, 4095);
      spheres_pending.push_back(make_sphere(32767, 32767, 32767, 255));
      spheres_pending.push_back(make_sphere(-32768, -32768, -32768, 255));
      spheres_pending.push_back(make_sphere(0, 0, 0, 128));
      spheres_pending.push_back(make_sphere(-32768, 32767, -32768, 3));
      drain();
      write_camera(2047, -2048, 2047, -2048, 32767, 32767, 32767, 0);
      spheres_pending.push_back(make_sphere(-32768, -32768, -32768, 255));
      spheres_pending.push_back(make_sphere(32767, 0, -32768, 9));
      spheres_pending.push_back(make_sphere(-1, 1, -1, 77));
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         int a, b;
         phase_no = ph;
         case (ph % 4)
            0: write_camera(1024, 0, 1024, 0, 0, 0, 0, 256);
            1: write_camera(1024, 1024, 1024, 1024, 32767, -32768, 0, 4095);
            default: begin
               a = $urandom_range(2048) - 1024;
               b = $urandom_range(2048) - 1024;
               if ($urandom_range(4) == 0) begin
                  a = $urandom_range(4095);
                  b = $urandom_range(4095);
               end
               write_camera(a, b, $urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                            $urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(4095));
            end
         endcase
         for (int i = 0; i < PER_PHASE; i++)
            spheres_pending.push_back(random_sphere());
         drain();
      end
      phase_no = NUM_PHASES;

      $display("Sent %0d spheres over %0d camera settings; %0d visible, %0d culled.",
               spheres_sent, NUM_PHASES + 3, visible_seen, culled_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
